// ----- src/dfp_pkg.sv -----
`timescale 1ns / 1ps

package dfp_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned SQ_W    = 66;
    localparam int unsigned ROOT_W  = 35;
    localparam int unsigned NUM_W   = 62;
    localparam int unsigned NUMSH_W = 98;
    localparam int unsigned DEN_W   = 101;
    localparam int unsigned QUO_W   = 33;
    localparam int unsigned PROD_W  = 68;

    localparam logic [28:0] INV_FOUR_PI_Q32 = 29'd341782638;

    localparam logic [1:0] CFG_DIPOLE_X = 2'd0;
    localparam logic [1:0] CFG_DIPOLE_Y = 2'd1;
    localparam logic [1:0] CFG_DIPOLE_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] sensor_x;
        logic signed [31:0] sensor_y;
        logic signed [31:0] sensor_z;
        logic signed [31:0] sum_y_in;
        logic signed [31:0] sum_z_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sum_y_out;
        logic signed [31:0] sum_z_out;
        logic               saturated;
        logic               zero_distance;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] sum_y;
        logic signed [31:0] sum_z;
        logic [NUM_W-1:0]   num_y;
        logic [NUM_W-1:0]   num_z;
        logic               neg_y;
        logic               neg_z;
        logic               zero;
    } t_side;

endpackage

// ----- src/dfp_sqrt.sv -----
`timescale 1ns / 1ps

module dfp_sqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [65:0]           i_s,
    input  dfp_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [65:0]           o_s,
    output logic [34:0]           o_root,
    output dfp_pkg::t_side        o_side
);
    import dfp_pkg::*;

    logic              r_v    [0:ROOT_W];
    logic [SQ_W-1:0]   r_s    [0:ROOT_W];
    logic [SQ_W-1:0]   r_e    [0:ROOT_W];
    logic [ROOT_W-1:0] r_r    [0:ROOT_W];
    t_side             r_side [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_s[0]    <= i_s;
        r_e[0]    <= i_s;
        r_r[0]    <= '0;
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int B = ROOT_W - 1 - g;
        logic [71:0] n_trial;
        logic [72:0] n_diff;
        assign n_trial = (72'(r_r[g]) << (B + 1)) + (72'(1) << (2 * B));
        assign n_diff  = {7'b0, r_e[g]} - {1'b0, n_trial};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_s[g+1]    <= r_s[g];
            r_side[g+1] <= r_side[g];
            if (!n_diff[72]) begin
                r_e[g+1] <= n_diff[SQ_W-1:0];
                r_r[g+1] <= r_r[g] | (ROOT_W'(1) << B);
            end else begin
                r_e[g+1] <= r_e[g];
                r_r[g+1] <= r_r[g];
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_s     = r_s[ROOT_W];
    assign o_root  = r_r[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

// ----- src/dfp_div.sv -----
`timescale 1ns / 1ps

module dfp_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [100:0]          i_den,
    input  logic [97:0]           i_num_y,
    input  logic [97:0]           i_num_z,
    input  dfp_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [32:0]           o_q_y,
    output logic [32:0]           o_q_z,
    output logic                  o_clip_y,
    output logic                  o_clip_z,
    output dfp_pkg::t_side        o_side
);
    import dfp_pkg::*;

    localparam int unsigned WIDE = DEN_W + QUO_W;

    logic               r_v    [0:QUO_W];
    logic [DEN_W-1:0]   r_d    [0:QUO_W];
    logic [NUMSH_W-1:0] r_ry   [0:QUO_W];
    logic [NUMSH_W-1:0] r_rz   [0:QUO_W];
    logic [QUO_W-1:0]   r_qy   [0:QUO_W];
    logic [QUO_W-1:0]   r_qz   [0:QUO_W];
    logic               r_cy   [0:QUO_W];
    logic               r_cz   [0:QUO_W];
    t_side              r_side [0:QUO_W];

    logic [WIDE-1:0] n_dlim;
    assign n_dlim = {i_den, {QUO_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_d[0]    <= i_den;
        r_ry[0]   <= i_num_y;
        r_rz[0]   <= i_num_z;
        r_qy[0]   <= '0;
        r_qz[0]   <= '0;
        r_cy[0]   <= (WIDE'(i_num_y) >= n_dlim);
        r_cz[0]   <= (WIDE'(i_num_z) >= n_dlim);
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int SH = QUO_W - 1 - g;
        logic [WIDE-1:0] n_dsh;
        logic [WIDE:0]   n_dy;
        logic [WIDE:0]   n_dz;
        assign n_dsh = WIDE'(r_d[g]) << SH;
        assign n_dy  = {1'b0, WIDE'(r_ry[g])} - {1'b0, n_dsh};
        assign n_dz  = {1'b0, WIDE'(r_rz[g])} - {1'b0, n_dsh};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_d[g+1]    <= r_d[g];
            r_cy[g+1]   <= r_cy[g];
            r_cz[g+1]   <= r_cz[g];
            r_side[g+1] <= r_side[g];
            r_ry[g+1]   <= n_dy[WIDE] ? r_ry[g] : n_dy[NUMSH_W-1:0];
            r_rz[g+1]   <= n_dz[WIDE] ? r_rz[g] : n_dz[NUMSH_W-1:0];
            r_qy[g+1]   <= {r_qy[g][QUO_W-2:0], ~n_dy[WIDE]};
            r_qz[g+1]   <= {r_qz[g][QUO_W-2:0], ~n_dz[WIDE]};
        end
    end

    assign o_valid  = r_v[QUO_W];
    assign o_q_y    = r_qy[QUO_W];
    assign o_q_z    = r_qz[QUO_W];
    assign o_clip_y = r_cy[QUO_W];
    assign o_clip_z = r_cz[QUO_W];
    assign o_side   = r_side[QUO_W];

endmodule

// ----- src/dipole_field_point_eval_unit.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// input     i_start, o_busy, i_word                 taken when i_start and not o_busy
// result    o_strobe, o_result                      valid for one cycle, cannot be held
// config    i_cfg_we, i_cfg_idx, i_cfg_data         written when i_cfg_we is high
//
// One word is taken every cycle; o_busy is always low.
// Each word passes four front, product and output stages, 36 square root stages and 34
// quotient stages before its result is on the outputs.
// Reset clears all valid bits and the dipole position registers.
// The pipeline never stalls.

module dipole_field_point_eval_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  dfp_pkg::t_in_word    i_word,
    output logic                 o_strobe,
    output dfp_pkg::t_out_word   o_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import dfp_pkg::*;

    logic [31:0] r_dip_x, r_dip_y, r_dip_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_x <= '0;
            r_dip_y <= '0;
            r_dip_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIPOLE_X: r_dip_x <= i_cfg_data;
                CFG_DIPOLE_Y: r_dip_y <= i_cfg_data;
                CFG_DIPOLE_Z: r_dip_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic                r_v0;
    logic [DIFF_W-1:0]   r_rx, r_ry, r_rz;
    logic signed [31:0]  r_sy0, r_sz0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
        end
        r_rx  <= {i_word.sensor_x[31], i_word.sensor_x} - {r_dip_x[31], r_dip_x};
        r_ry  <= {i_word.sensor_y[31], i_word.sensor_y} - {r_dip_y[31], r_dip_y};
        r_rz  <= {i_word.sensor_z[31], i_word.sensor_z} - {r_dip_z[31], r_dip_z};
        r_sy0 <= i_word.sum_y_in;
        r_sz0 <= i_word.sum_z_in;
    end

    logic [DIFF_W-1:0] n_ax, n_ay, n_az;
    assign n_ax = r_rx[32] ? -r_rx : r_rx;
    assign n_ay = r_ry[32] ? -r_ry : r_ry;
    assign n_az = r_rz[32] ? -r_rz : r_rz;

    logic              r_v1;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_sqz;
    logic [NUM_W-1:0]  r_num_y, r_num_z;
    logic              r_neg_y, r_neg_z;
    logic signed [31:0] r_sy1, r_sz1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_sqx   <= SQ_W'(n_ax) * SQ_W'(n_ax);
        r_sqy   <= SQ_W'(n_ay) * SQ_W'(n_ay);
        r_sqz   <= SQ_W'(n_az) * SQ_W'(n_az);
        r_num_y <= NUM_W'(n_az) * NUM_W'(INV_FOUR_PI_Q32);
        r_num_z <= NUM_W'(n_ay) * NUM_W'(INV_FOUR_PI_Q32);
        r_neg_y <= !r_rz[32] && (r_rz != '0);
        r_neg_z <= r_ry[32];
        r_sy1   <= r_sy0;
        r_sz1   <= r_sz0;
    end

    logic [SQ_W-1:0] n_s;
    t_side           n_side;
    assign n_s = r_sqx + r_sqy + r_sqz;

    always_comb begin
        n_side.sum_y = r_sy1;
        n_side.sum_z = r_sz1;
        n_side.num_y = r_num_y;
        n_side.num_z = r_num_z;
        n_side.neg_y = r_neg_y;
        n_side.neg_z = r_neg_z;
        n_side.zero  = (n_s == '0);
    end

    logic              w_sq_valid;
    logic [SQ_W-1:0]   w_s;
    logic [ROOT_W-1:0] w_root;
    t_side             w_sq_side;

    dfp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_s     (n_s),
        .i_side  (n_side),
        .o_valid (w_sq_valid),
        .o_s     (w_s),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    logic              r_vm;
    logic [PROD_W-1:0] r_p_lo, r_p_hi;
    t_side             r_side_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= w_sq_valid;
        end
        r_p_lo   <= PROD_W'(w_s[32:0]) * PROD_W'(w_root);
        r_p_hi   <= PROD_W'(w_s[65:33]) * PROD_W'(w_root);
        r_side_m <= w_sq_side;
    end

    logic [DEN_W-1:0]   n_den;
    logic [NUMSH_W-1:0] n_ny, n_nz;
    assign n_den = (DEN_W'(r_p_hi) << 33) + DEN_W'(r_p_lo);
    assign n_ny  = {r_side_m.num_y, 36'b0};
    assign n_nz  = {r_side_m.num_z, 36'b0};

    logic             w_dv_valid;
    logic [QUO_W-1:0] w_q_y, w_q_z;
    logic             w_clip_y, w_clip_z;
    t_side            w_dv_side;

    dfp_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vm),
        .i_den    (n_den),
        .i_num_y  (n_ny),
        .i_num_z  (n_nz),
        .i_side   (r_side_m),
        .o_valid  (w_dv_valid),
        .o_q_y    (w_q_y),
        .o_q_z    (w_q_z),
        .o_clip_y (w_clip_y),
        .o_clip_z (w_clip_z),
        .o_side   (w_dv_side)
    );

    logic [33:0]        n_mag_y, n_mag_z;
    logic signed [35:0] n_t_y, n_t_z, n_v_y, n_v_z;
    logic               n_sat_y, n_sat_z;
    t_out_word          n_result;

    always_comb begin
        n_mag_y = w_clip_y ? (34'(1) << 33) : {1'b0, w_q_y};
        n_mag_z = w_clip_z ? (34'(1) << 33) : {1'b0, w_q_z};
        n_t_y   = w_dv_side.neg_y ? -signed'(36'(n_mag_y)) : signed'(36'(n_mag_y));
        n_t_z   = w_dv_side.neg_z ? -signed'(36'(n_mag_z)) : signed'(36'(n_mag_z));
        n_v_y   = 36'(w_dv_side.sum_y) + n_t_y;
        n_v_z   = 36'(w_dv_side.sum_z) + n_t_z;
        n_sat_y = (n_v_y[35:31] != '0) && (n_v_y[35:31] != '1);
        n_sat_z = (n_v_z[35:31] != '0) && (n_v_z[35:31] != '1);
        if (w_dv_side.zero) begin
            n_result.sum_y_out     = w_dv_side.sum_y;
            n_result.sum_z_out     = w_dv_side.sum_z;
            n_result.saturated     = 1'b0;
            n_result.zero_distance = 1'b1;
        end else begin
            n_result.sum_y_out = n_sat_y ? (n_v_y[35] ? 32'sh80000000 : 32'sh7fffffff)
                                         : n_v_y[31:0];
            n_result.sum_z_out = n_sat_z ? (n_v_z[35] ? 32'sh80000000 : 32'sh7fffffff)
                                         : n_v_z[31:0];
            n_result.saturated     = n_sat_y || n_sat_z || w_clip_y || w_clip_z;
            n_result.zero_distance = 1'b0;
        end
    end

    logic      r_strobe;
    t_out_word r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_dv_valid;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_valid |-> ((70'(w_root) * 70'(w_root)) <= 70'(w_s)))
        else $error("square root too large");
    a_root_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_valid |-> ((70'(w_root) + 70'(1)) * (70'(w_root) + 70'(1)) > 70'(w_s)))
        else $error("square root too small");
    a_zero_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.zero_distance) |-> !o_result.saturated)
        else $error("zero distance result marked saturated");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");
`endif

endmodule
